// ===== rtl/irtpe_pkg.sv =====
// shared types and constants of the ir tag packet pulse encoder
package irtpe_pkg;

  localparam int unsigned SHOT_BITS  = 14;
  localparam int unsigned MSG_BITS   = 3 * 8;
  localparam int unsigned CNT_W      = 6;
  localparam logic [CNT_W-1:0] SHOT_LAST = CNT_W'(2 * SHOT_BITS);
  localparam logic [CNT_W-1:0] MSG_LAST  = CNT_W'(2 * MSG_BITS);
  localparam logic [7:0] END_BYTE    = 8'hE8;
  localparam logic [7:0] PLAYER_MASK = 8'b0111_1111;
  localparam logic [7:0] DAMAGE_MASK = 8'b0000_1111;

  typedef enum logic [2:0] {
    CMD_SHOT        = 3'd0,
    CMD_ADD_HEALTH  = 3'd1,
    CMD_ADD_ROUNDS  = 3'd2,
    CMD_SYSTEM      = 3'd3,
    CMD_AMMO        = 3'd4,
    CMD_HEALTH      = 3'd5,
    CMD_FLAG_PICKUP = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_PLAYER_ID     = 3'd0,
    CFG_TEAM_ID       = 3'd1,
    CFG_HEADER_LENGTH = 3'd2,
    CFG_ONE_LENGTH    = 3'd3,
    CFG_ZERO_LENGTH   = 3'd4,
    CFG_GAP_LENGTH    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic        pulse_level;
    logic [15:0] pulse_length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [6:0]  player_id;
    logic [1:0]  team_id;
    logic [15:0] header_length;
    logic [15:0] one_length;
    logic [15:0] zero_length;
    logic [15:0] gap_length;
  } cfg_t;

  typedef struct packed {
    logic        shot;
    logic [23:0] packet;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  function automatic logic [7:0] opcode_of(logic [2:0] cmd);
    logic [7:0] op;
    case (cmd)
      CMD_ADD_HEALTH:  op = 8'h80;
      CMD_ADD_ROUNDS:  op = 8'h81;
      CMD_SYSTEM:      op = 8'h83;
      CMD_AMMO:        op = 8'h8A;
      CMD_HEALTH:      op = 8'h8B;
      CMD_FLAG_PICKUP: op = 8'h8C;
      default:         op = 8'h00;
    endcase
    return op;
  endfunction

endpackage

// ===== rtl/irtpe_front.sv =====
// front end: takes a request, classifies it and builds the packet bits
module irtpe_front (
  input  logic              start_i,
  input  logic              full_i,
  input  irtpe_pkg::req_t   req_i,
  input  irtpe_pkg::cfg_t   cfg_i,
  output irtpe_pkg::push_t  push_o
);

  logic       known;
  logic [7:0] damage;
  logic [7:0] byte0;
  logic [7:0] byte1;

  always_comb begin
    known  = (req_i.cmd <= irtpe_pkg::CMD_FLAG_PICKUP);
    damage = req_i.value & irtpe_pkg::DAMAGE_MASK;
    byte0  = {1'b0, cfg_i.player_id} & irtpe_pkg::PLAYER_MASK;
    byte1  = {cfg_i.team_id, damage[3:0], 2'b00};
    push_o.push = start_i && !full_i && known;
    if (req_i.cmd == irtpe_pkg::CMD_SHOT) begin
      push_o.entry.shot   = 1'b1;
      push_o.entry.packet = {byte0, byte1, 8'h00};
    end else begin
      push_o.entry.shot   = 1'b0;
      push_o.entry.packet = {irtpe_pkg::opcode_of(req_i.cmd), req_i.value,
                             irtpe_pkg::END_BYTE};
    end
  end

endmodule

// ===== rtl/irtpe_fifo.sv =====
// two-entry packet queue between front and back
module irtpe_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irtpe_pkg::push_t  push_i,
  input  logic              pop_i,
  output irtpe_pkg::head_t  head_o,
  output logic              full_o
);

  irtpe_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i.push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i.push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];
  assign full_o       = count_q[1];

endmodule

// ===== rtl/irtpe_back.sv =====
// back end: unrolls one packet into mark and space beats
module irtpe_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irtpe_pkg::head_t  head_i,
  input  irtpe_pkg::cfg_t   cfg_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output irtpe_pkg::res_t   res_o
);

  logic                        active_q, active_d;
  logic [irtpe_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [23:0]                 shreg_q, shreg_d;
  logic                        shot_q, shot_d;
  logic                        res_valid_q;
  irtpe_pkg::res_t             res_q, res_d;
  logic                        is_header;
  logic                        is_gap;
  logic                        is_last;

  always_comb begin
    is_header = (cnt_q == '0);
    is_gap    = cnt_q[0];
    is_last   = active_q &&
                (cnt_q == (shot_q ? irtpe_pkg::SHOT_LAST : irtpe_pkg::MSG_LAST));
    pop_o     = head_i.valid && (!active_q || is_last);

    active_d = active_q;
    cnt_d    = cnt_q;
    shreg_d  = shreg_q;
    shot_d   = shot_q;
    if (pop_o) begin
      active_d = 1'b1;
      cnt_d    = '0;
      shreg_d  = head_i.entry.packet;
      shot_d   = head_i.entry.shot;
    end else if (is_last) begin
      active_d = 1'b0;
    end else if (active_q) begin
      cnt_d = cnt_q + 1'b1;
      if (!is_header && !is_gap) begin
        shreg_d = {shreg_q[22:0], 1'b0};
      end
    end

    res_d.pulse_level = !is_gap;
    res_d.last        = is_last;
    if (is_header) begin
      res_d.pulse_length = cfg_i.header_length;
    end else if (is_gap) begin
      res_d.pulse_length = cfg_i.gap_length;
    end else begin
      res_d.pulse_length = shreg_q[23] ? cfg_i.one_length : cfg_i.zero_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      res_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    shreg_q <= shreg_d;
    shot_q  <= shot_d;
    res_q   <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/ir_tag_packet_pulse_encoder.sv =====
// top level of the ir tag packet pulse encoder
// a request goes via queue, back end state and output register; then one beat per cycle
// a shot gives 29 beats and a message 49; the back end's beat counter ends the packet
// up to two requests queue ahead of the back end; busy is high while the queue is full
// reset clears control state and loads the register defaults; the receiver cannot stall
module ir_tag_packet_pulse_encoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  irtpe_pkg::req_t  req_i,
  output logic             res_valid_o,
  output irtpe_pkg::res_t  res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);

  irtpe_pkg::cfg_t  cfg_q, cfg_d;
  irtpe_pkg::push_t push;
  irtpe_pkg::head_t head;
  logic             pop;
  logic             full;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        irtpe_pkg::CFG_PLAYER_ID:     cfg_d.player_id     = cfg_data_i[6:0];
        irtpe_pkg::CFG_TEAM_ID:       cfg_d.team_id       = cfg_data_i[1:0];
        irtpe_pkg::CFG_HEADER_LENGTH: cfg_d.header_length = cfg_data_i;
        irtpe_pkg::CFG_ONE_LENGTH:    cfg_d.one_length    = cfg_data_i;
        irtpe_pkg::CFG_ZERO_LENGTH:   cfg_d.zero_length   = cfg_data_i;
        irtpe_pkg::CFG_GAP_LENGTH:    cfg_d.gap_length    = cfg_data_i;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.player_id     <= 7'd15;
      cfg_q.team_id       <= 2'd0;
      cfg_q.header_length <= 16'd2400;
      cfg_q.one_length    <= 16'd1200;
      cfg_q.zero_length   <= 16'd600;
      cfg_q.gap_length    <= 16'd600;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irtpe_front u_front (
    .start_i (start),
    .full_i  (full),
    .req_i   (req_i),
    .cfg_i   (cfg_q),
    .push_o  (push)
  );

  irtpe_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  irtpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .cfg_i       (cfg_q),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  assign busy = full;

`ifndef SYNTHESIS
  a_last_is_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> res_o.pulse_level)
    else $error("last beat is not a mark");

  a_train_alternates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=>
      res_valid_o && (res_o.pulse_level != $past(res_o.pulse_level)))
    else $error("pulse train broken or not alternating");

  a_next_is_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o || (res_o.pulse_level && !res_o.last))
    else $error("train after last beat does not open with a header");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push.push)
    else $error("queue written while full");
`endif

endmodule
